// ===== hdl/mslu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mslu_pkg
// Shared constants, types and helpers of the multi-stream Lehmer uniform core.
// ----------------------------------------------------------------------------
package mslu_pkg;

  // field widths
  localparam int unsigned STREAM_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SEED_W   = 31;

  // generator constants
  localparam logic [SEED_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam int unsigned       MUL_BITS   = 15;
  localparam logic [MUL_BITS-1:0] LEHMER_MUL = 15'd16807;

  // stream table
  localparam int unsigned DEFAULT_NUM_STREAMS = 8;
  localparam int unsigned IDX_MAX_W           = 8;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // wrap a stream index into the table depth by repeated subtraction
  function automatic logic [IDX_MAX_W-1:0] wrap_index(input logic [STREAM_W-1:0] s,
                                                      input int unsigned n);
    logic [IDX_MAX_W:0] v;
    logic [IDX_MAX_W:0] n_v;
    v   = {{(IDX_MAX_W + 1 - STREAM_W){1'b0}}, s};
    n_v = (IDX_MAX_W + 1)'(n);
    for (int i = 0; i < (1 << STREAM_W); i++) begin
      if (v >= n_v) begin
        v = v - n_v;
      end
    end
    return v[IDX_MAX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mslu_seed_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mslu_seed_mem
// Seed table with one registered read port, one write port and a valid bit
// per entry; an entry never written reads as its index plus one.
// ----------------------------------------------------------------------------
module mslu_seed_mem #(
  parameter int unsigned NUM_STREAMS = mslu_pkg::DEFAULT_NUM_STREAMS,
  localparam int unsigned IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [IDX_W-1:0]            rd_addr,
  output logic      [mslu_pkg::SEED_W-1:0] rd_data,
  input  wire logic                        wr_en,
  input  wire logic [IDX_W-1:0]            wr_addr,
  input  wire logic [mslu_pkg::SEED_W-1:0] wr_data
);
  import mslu_pkg::*;

  logic [SEED_W-1:0]      mem [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] valid;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= SEED_W'(rd_addr) + SEED_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mslu_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mslu_mulmod
// Bit-serial multiply of a seed by the Lehmer multiplier modulo 2^31-1,
// one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mslu_mulmod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mslu_pkg::SEED_W-1:0] seed_in,
  output mslu_pkg::unit_status_t           status,
  output logic      [mslu_pkg::SEED_W-1:0] result
);
  import mslu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_BITS);

  logic [SEED_W-1:0]   acc;
  logic [SEED_W-1:0]   mcand;
  logic [MUL_BITS-1:0] mbits;
  logic [CNT_W-1:0]    count;
  logic                busy;
  logic                done;

  logic [SEED_W-1:0] dbl;
  logic [SEED_W:0]   sum;
  logic [SEED_W:0]   sum_red;
  logic [SEED_W-1:0] acc_next;

  // doubling modulo 2^31-1 is a rotate, then add and reduce once
  always_comb begin
    dbl     = {acc[SEED_W-2:0], acc[SEED_W-1]};
    sum     = {1'b0, dbl} + (mbits[MUL_BITS-1] ? {1'b0, mcand} : '0);
    sum_red = (sum >= {1'b0, LEHMER_MOD}) ? (sum - {1'b0, LEHMER_MOD}) : sum;
    acc_next = sum_red[SEED_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(MUL_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= seed_in;
      mbits <= LEHMER_MUL;
    end else if (busy) begin
      acc   <= acc_next;
      mbits <= {mbits[MUL_BITS-2:0], 1'b0};
    end
  end

  // a zero residue becomes the multiplier itself
  assign result      = (acc == '0) ? SEED_W'(LEHMER_MUL) : acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

// ===== hdl/mslu_rem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mslu_rem
// Bit-serial restoring remainder of a 31-bit seed by a 32-bit range width,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mslu_rem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mslu_pkg::SEED_W-1:0] dividend,
  input  wire logic [mslu_pkg::DATA_W-1:0] divisor,
  output mslu_pkg::unit_status_t           status,
  output logic      [mslu_pkg::DATA_W-1:0] rem
);
  import mslu_pkg::*;

  localparam int unsigned CNT_W = $clog2(SEED_W);

  logic [SEED_W-1:0] dvd;
  logic [DATA_W-1:0] dsr;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              done;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_red;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial     = {rem, dvd[SEED_W-1]};
    trial_red = (trial >= {1'b0, dsr}) ? (trial - {1'b0, dsr}) : trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(SEED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SEED_W-2:0], 1'b0};
      rem <= trial_red[DATA_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

// ===== hdl/multi_stream_lehmer_uniform_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stream_lehmer_uniform_core
// Multi-stream minimal standard Lehmer generator returning uniform values in
// a requested half-open range.
// ----------------------------------------------------------------------------
// Each transaction names a stream and a range [base, limit). The stream's seed
// is read from the table, advanced by a bit-serial multiply modulo 2^31-1
// (one multiplier bit per cycle) and written back, then reduced modulo
// limit-base by a bit-serial remainder unit (one seed bit per cycle) and added
// to base. When limit is not above base the remainder is skipped and the
// result is base with range_error set; the seed still advances. One
// transaction is processed at a time; the core is ready for the next one in
// the same cycle that the result is offered, even while that result still
// waits in the output register. Stream indexes at or above NUM_STREAMS wrap
// modulo NUM_STREAMS; the seed table starts at 1..N.
// ----------------------------------------------------------------------------
module multi_stream_lehmer_uniform_core #(
  parameter int unsigned NUM_STREAMS = mslu_pkg::DEFAULT_NUM_STREAMS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mslu_pkg::STREAM_W-1:0] stream,
  input  wire logic [mslu_pkg::DATA_W-1:0]   base,
  input  wire logic [mslu_pkg::DATA_W-1:0]   limit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [mslu_pkg::DATA_W-1:0]   value,
  output logic                               range_error
);
  import mslu_pkg::*;

  localparam int unsigned IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] base_q;
  logic [DATA_W-1:0] width_q;
  logic              err_q;
  logic [DATA_W-1:0] value_q;

  logic [IDX_MAX_W-1:0] idx_wide;
  logic [IDX_W-1:0]     idx_in;
  logic                 accept;
  logic [SEED_W-1:0]    rd_seed;
  logic [SEED_W-1:0]    new_seed;
  logic [DATA_W-1:0]    rem;
  logic                 mul_start;
  logic                 seed_wr;
  logic                 div_start;
  unit_status_t         mul_st;
  unit_status_t         rem_st;

  // input handshake and index wrap
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_wide = wrap_index(stream, NUM_STREAMS);
  assign idx_in   = idx_wide[IDX_W-1:0];

  // unit sequencing
  assign mul_start = (state == S_READ);
  assign seed_wr   = (state == S_MUL) && mul_st.done;
  assign div_start = seed_wr && !err_q;

  mslu_seed_mem #(
    .NUM_STREAMS(NUM_STREAMS)
  ) u_seed_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(idx_in),
    .rd_data(rd_seed),
    .wr_en  (seed_wr),
    .wr_addr(idx),
    .wr_data(new_seed)
  );

  mslu_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .seed_in(rd_seed),
    .status (mul_st),
    .result (new_seed)
  );

  mslu_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(new_seed),
    .divisor (width_q),
    .status  (rem_st),
    .rem     (rem)
  );

  // request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx     <= idx_in;
      base_q  <= base;
      width_q <= limit - base;
      err_q   <= !(limit > base);
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a result taken while no new one is loaded empties the output register
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_st.done) begin
            if (err_q) begin
              value_q <= base_q;
              state   <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem_st.done) begin
            value_q <= base_q + rem;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            value       <= value_q;
            range_error <= err_q;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the serial units are quiet whenever no transaction is in flight
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mul_st.busy && !rem_st.busy))
    else $error("serial unit busy while idle");

  // a seed write back only happens at the end of the multiply
  a_wr_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |-> (state == S_MUL))
    else $error("multiply finished outside its phase");

  // the remainder finishes only while the sequencer waits for it
  a_rem_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_st.done |-> (state == S_DIV))
    else $error("remainder finished outside its phase");

  // an accepted transaction always starts with a table read
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted transaction did not start a table read");

endmodule
`default_nettype wire

// ===== dv/tb_multi_stream_lehmer_uniform_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_multi_stream_lehmer_uniform_core
// Self-checking bench for the multi-stream Lehmer uniform core: requests go in
// through the valid/ready input channel, a local copy of the seed table
// predicts every result, and each result is compared in order as it leaves.
// ----------------------------------------------------------------------------
module tb_multi_stream_lehmer_uniform_core;

  localparam int unsigned STREAM_W       = mslu_pkg::STREAM_W;
  localparam int unsigned DATA_W         = mslu_pkg::DATA_W;
  localparam int unsigned SEED_W         = mslu_pkg::SEED_W;
  localparam int unsigned STREAM_COUNT   = mslu_pkg::DEFAULT_NUM_STREAMS;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RANDOM_PER_MODE = 205;
  localparam logic [DATA_W-1:0] WORD_MAX = '1;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              range_error;
  } uniform_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [STREAM_W-1:0] stream;
  logic [DATA_W-1:0]   base;
  logic [DATA_W-1:0]   limit;
  logic                out_valid;
  logic                out_ready;
  logic [DATA_W-1:0]   value;
  logic                range_error;

  // predictor state and pending results
  logic [SEED_W-1:0] seed_state [STREAM_COUNT];
  uniform_result_t   expected_results [$];
  uniform_result_t   due;

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        holdoff_req;
  int unsigned holdoff_left;

  multi_stream_lehmer_uniform_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream      (stream),
    .base        (base),
    .limit       (limit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .range_error (range_error)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // one step of the minimal standard generator, zero replaced by the multiplier
  function automatic logic [SEED_W-1:0] lehmer_advance(input logic [SEED_W-1:0] s);
    logic [63:0]       prod;
    logic [SEED_W-1:0] nxt;
    prod = 64'(s) * 64'(mslu_pkg::LEHMER_MUL);
    nxt  = SEED_W'(prod % 64'(mslu_pkg::LEHMER_MOD));
    if (nxt == '0) begin
      nxt = SEED_W'(mslu_pkg::LEHMER_MUL);
    end
    return nxt;
  endfunction

  // advance the named stream and form the uniform value in [b, l)
  function automatic uniform_result_t predict_uniform(input logic [STREAM_W-1:0] s,
                                                      input logic [DATA_W-1:0] b,
                                                      input logic [DATA_W-1:0] l);
    int unsigned       slot;
    logic [SEED_W-1:0] seed;
    logic [DATA_W-1:0] width;
    uniform_result_t   r;
    slot = int'(s) % STREAM_COUNT;
    seed = lehmer_advance(seed_state[slot]);
    seed_state[slot] = seed;
    if (l > b) begin
      width         = l - b;
      r.value       = b + ({1'b0, seed} % width);
      r.range_error = 1'b0;
    end else begin
      r.value       = b;
      r.range_error = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // offer one request, with random idle cycles first, and wait for acceptance
  task automatic send_request(input logic [STREAM_W-1:0] s, input logic [DATA_W-1:0] b,
                              input logic [DATA_W-1:0] l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    stream   <= s;
    base     <= b;
    limit    <= l;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_uniform(s, b, l));
  endtask

  // stop offering and wait until every pending result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // random request: mostly valid ranges of assorted widths, some empty or inverted
  task automatic random_request();
    logic [STREAM_W-1:0] s;
    logic [DATA_W-1:0]   b;
    logic [DATA_W-1:0]   l;
    logic [DATA_W-1:0]   w;
    s = STREAM_W'($urandom_range(STREAM_COUNT - 1));
    b = $urandom;
    l = $urandom;
    case ($urandom_range(9))
      0: begin
        if (l > b) begin
          {b, l} = {l, b};
        end
        if ($urandom_range(3) == 0) begin
          l = b;
        end
      end
      1, 2, 3: begin
        w = $urandom_range(64, 1);
        if (b > WORD_MAX - w) b = WORD_MAX - w;
        l = b + w;
      end
      4, 5: begin
        w = DATA_W'(1) << $urandom_range(DATA_W - 1);
        if (b > WORD_MAX - w) b = WORD_MAX - w;
        l = b + w;
      end
      default: begin
        if (l < b) begin
          {b, l} = {l, b};
        end
      end
    endcase
    send_request(s, b, l);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_req && holdoff_left == 0) begin
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready    <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h", value));
      end else begin
        due = expected_results.pop_front();
        if (value !== due.value) begin
          report_mismatch($sformatf("value %h, expected %h", value, due.value));
        end
        if (range_error !== due.range_error) begin
          report_mismatch($sformatf("range_error %b, expected %b", range_error,
                                    due.range_error));
        end
      end
    end
  end

  // extremes of the range fields
  task automatic test_range_extremes();
    send_request(3'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(3'd1, 32'h0000_0000, 32'h0000_0001);
    send_request(3'd2, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(3'd3, 32'h0000_0000, 32'h0000_0002);
    send_request(3'd4, 32'h0000_0000, 32'h8000_0000);
    send_request(3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // empty and inverted ranges: base returned, flag set, seed still advances
  task automatic test_range_errors();
    send_request(3'd0, 32'h0000_0000, 32'h0000_0000);
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd6, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(3'd0, 32'h0000_0005, 32'h0000_0004);
  endtask

  // each stream once, checks independence of the seeds
  task automatic test_every_stream();
    for (int i = 0; i < STREAM_COUNT; i++) begin
      send_request(STREAM_W'(i), 32'h0000_1000, 32'h0000_1000 + 32'($urandom_range(999, 1)));
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req <= 1'b1;
    @(posedge clk);
    holdoff_req <= 1'b0;
    repeat (12) random_request();
    wait_drained();
  endtask

  // random traffic under each idling mode, pausing now and then to drain
  task automatic test_random_traffic();
    int unsigned idle_mode [4][2] = '{'{0, 0}, '{81, 0}, '{0, 81}, '{37, 37}};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_mode[m][0];
      recv_stall_pct = idle_mode[m][1];
      for (int n = 0; n < RANDOM_PER_MODE; n++) begin
        random_request();
        if (n % 50 == 49) wait_drained();
      end
      wait_drained();
    end
  endtask

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    stream         = '0;
    base           = '0;
    limit          = '0;
    out_ready      = 1'b0;
    holdoff_req    = 1'b0;
    holdoff_left   = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < STREAM_COUNT; i++) begin
      seed_state[i] = SEED_W'(i + 1);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // a stream index past the table or a zero product cannot arise with
    // eight streams and a prime modulus, so neither is driven
    test_range_extremes();
    test_range_errors();
    test_every_stream();
    wait_drained();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/mslu_pkg.sv
hdl/mslu_seed_mem.sv
hdl/mslu_mulmod.sv
hdl/mslu_rem.sv
hdl/multi_stream_lehmer_uniform_core.sv
dv/tb_multi_stream_lehmer_uniform_core.sv
